[src/sfpc_pkg.sv]
package sfpc_pkg;

  // Packet geometry.
  localparam int PACKET_BYTES = 64;
  localparam int ADDR_W       = $clog2(PACKET_BYTES);
  localparam int CNT_W        = $clog2(PACKET_BYTES + 1);
  localparam int CRC_WORDS    = PACKET_BYTES / 4 - 1;
  localparam int CHECK_BASE   = PACKET_BYTES - 4;

  // Framing and CRC constants.
  localparam logic [7:0]  SYNC_FIRST  = 8'h54;
  localparam logic [7:0]  SYNC_SECOND = 8'hDC;
  localparam logic [31:0] CRC_POLY    = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_TOP     = 32'h8000_0000;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_GOOD = 2'd0,
    ST_LEN  = 2'd1,
    ST_CRC  = 2'd2
  } status_e;

  // Command from the controller to the CRC unit.
  typedef struct packed {
    logic       init;
    logic       feed;
    logic [7:0] data;
  } crc_cmd_t;

endpackage

[src/sfpc_if.sv]
// Received byte channel.
interface sfpc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Result channel.
interface sfpc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [5:0] byte_index;
  logic       last;
  logic [1:0] status;

  modport source (output valid, output out_byte, output byte_index, output last,
                  output status, input ready);
  modport sink (input valid, input out_byte, input byte_index, input last,
                input status, output ready);
endinterface

[src/sfpc_ram.sv]
module sfpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/sfpc_crc.sv]
module sfpc_crc import sfpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  crc_cmd_t    cmd_i,
  output logic [31:0] crc_o
);

  logic [31:0] crc_q;
  logic [31:0] crc_d;

  // MSB-first CRC-32 update by one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'h000000};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 32'h0) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  // Restart on a new packet, otherwise fold in one byte when asked.
  always_comb begin
    crc_d = crc_q;
    if (cmd_i.init) begin
      crc_d = CRC_INIT;
    end else if (cmd_i.feed) begin
      crc_d = crc_byte(crc_q, cmd_i.data);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

[src/sync_framed_packet_crc_checker_unit.sv]
// Sync-framed packet receiver with a CRC-32/MPEG-2 word check. Bytes enter one
// at a time on rx_i; the unit hunts for the pair 0x54, 0xDC, stores a
// packet of PACKET_BYTES bytes (sync pair included) in a single packet RAM,
// and then checks the length byte at offset 2 and the CRC against the
// little-endian check word in the last four bytes. A good packet is replayed
// byte by byte on res_o with last set on the final byte; a bad one gives a
// single word with last set and status 1 (length) or 2 (CRC).
// While hunting or reading, one byte is accepted per cycle. After the sync
// pair the input is held in S_SYNC1 and S_SYNC2 while both sync bytes are
// written through the RAM's one write port. After the fourth byte of each
// CRC-covered word the input is held in S_CRC, since the byte-wide CRC unit
// folds the gathered word in one byte per cycle. A good packet replays byte
// by byte; a new RAM read is issued only once the previous byte has reached
// the output register and that register is free.
module sync_framed_packet_crc_checker_unit import sfpc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  sfpc_rx_if.sink      rx_i,
  sfpc_res_if.source   res_o
);

  typedef enum logic [7:0] {
    S_HUNT1  = 8'b0000_0001,
    S_HUNT2  = 8'b0000_0010,
    S_SYNC1  = 8'b0000_0100,
    S_SYNC2  = 8'b0000_1000,
    S_READ   = 8'b0001_0000,
    S_CRC    = 8'b0010_0000,
    S_CHECK  = 8'b0100_0000,
    S_REPLAY = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [23:0]       gather_q, gather_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [7:0]        len_q, len_d;
  logic [31:0]       chk_q, chk_d;
  logic [ADDR_W-1:0] rp_q, rp_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] pend_idx_q, pend_idx_d;
  logic              pend_last_q, pend_last_d;

  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic [5:0]        out_idx_q, out_idx_d;
  logic              out_last_q, out_last_d;
  status_e           out_status_q, out_status_d;

  logic        in_acc;
  logic        out_free;
  logic        take_v;
  logic [7:0]  take_b;
  logic [1:0]  lane;
  logic        in_crc;
  logic        word_done;
  logic        issue;
  logic        fail_load;
  status_e     chk_status;
  crc_cmd_t    crc_cmd;
  logic [31:0] crc_val;
  logic [7:0]  rdata;

  assign in_acc   = rx_i.valid && rx_i.ready;
  assign out_free = !out_valid_q || res_o.ready;

  // Input is open only while hunting or reading packet bytes.
  assign rx_i.ready = (state_q == S_HUNT1) || (state_q == S_HUNT2) ||
                      (state_q == S_READ);

  // Byte to store this cycle: a sync byte or a received byte.
  always_comb begin
    take_v = 1'b0;
    take_b = rx_i.rx_byte;
    unique case (state_q)
      S_SYNC1: begin
        take_v = 1'b1;
        take_b = SYNC_FIRST;
      end
      S_SYNC2: begin
        take_v = 1'b1;
        take_b = SYNC_SECOND;
      end
      S_READ: begin
        take_v = in_acc;
      end
      default: begin
        take_v = 1'b0;
      end
    endcase
  end

  assign lane      = fill_q[1:0];
  assign in_crc    = (fill_q >> 2) < CNT_W'(CRC_WORDS);
  assign word_done = take_v && in_crc && (lane == 2'd3);

  // Packet check after the last byte: length first, then CRC.
  always_comb begin
    if (9'(len_q) != 9'(PACKET_BYTES)) begin
      chk_status = ST_LEN;
    end else if (chk_q != crc_val) begin
      chk_status = ST_CRC;
    end else begin
      chk_status = ST_GOOD;
    end
  end

  assign fail_load = (state_q == S_CHECK) && out_free && !pend_q &&
                     (chk_status != ST_GOOD);
  assign issue     = (state_q == S_REPLAY) && !pend_q && out_free;

  // CRC unit commands: restart on sync, fold the word top byte first.
  always_comb begin
    crc_cmd.init = (state_q == S_HUNT2) && in_acc && (rx_i.rx_byte == SYNC_SECOND);
    crc_cmd.feed = word_done || (state_q == S_CRC);
    crc_cmd.data = (state_q == S_CRC) ? gather_q[23:16] : take_b;
  end

  // Sequencer and packet bookkeeping.
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    gather_d    = gather_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    chk_d       = chk_q;
    rp_d        = rp_q;
    pend_d      = issue;
    pend_idx_d  = pend_idx_q;
    pend_last_d = pend_last_q;

    if (take_v) begin
      fill_d = fill_q + CNT_W'(1);
      if (in_crc && (lane != 2'd3)) begin
        gather_d = gather_q | (24'(take_b) << {lane, 3'b000});
      end
      if (fill_q == CNT_W'(2)) begin
        len_d = take_b;
      end
      if (fill_q >= CNT_W'(CHECK_BASE)) begin
        chk_d = {take_b, chk_q[31:8]};
      end
    end

    unique case (state_q)
      S_HUNT1: begin
        if (in_acc && (rx_i.rx_byte == SYNC_FIRST)) begin
          state_d = S_HUNT2;
        end
      end
      S_HUNT2: begin
        if (in_acc) begin
          if (rx_i.rx_byte == SYNC_SECOND) begin
            state_d  = S_SYNC1;
            fill_d   = '0;
            gather_d = '0;
          end else begin
            state_d = S_HUNT1;
          end
        end
      end
      S_SYNC1: begin
        state_d = S_SYNC2;
      end
      S_SYNC2: begin
        state_d = S_READ;
      end
      S_READ: begin
        if (take_v) begin
          if (word_done) begin
            state_d = S_CRC;
            cnt_d   = '0;
          end else if (fill_q == CNT_W'(PACKET_BYTES - 1)) begin
            state_d = S_CHECK;
          end
        end
      end
      S_CRC: begin
        // Shift the gathered bytes out; the word register ends at zero.
        gather_d = gather_q << 8;
        cnt_d    = cnt_q + 2'd1;
        if (cnt_q == 2'd2) begin
          state_d = S_READ;
        end
      end
      S_CHECK: begin
        if (out_free && !pend_q) begin
          if (chk_status != ST_GOOD) begin
            state_d = S_HUNT1;
          end else begin
            state_d = S_REPLAY;
            rp_d    = '0;
          end
        end
      end
      S_REPLAY: begin
        if (issue) begin
          pend_idx_d  = rp_q;
          pend_last_d = (rp_q == ADDR_W'(PACKET_BYTES - 1));
          rp_d        = rp_q + ADDR_W'(1);
          if (rp_q == ADDR_W'(PACKET_BYTES - 1)) begin
            state_d = S_HUNT1;
          end
        end
      end
      default: begin
        state_d = S_HUNT1;
      end
    endcase
  end

  // Output register: loaded from the RAM read or with a failure word.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_idx_d    = out_idx_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (pend_q) begin
      out_valid_d  = 1'b1;
      out_byte_d   = rdata;
      out_idx_d    = 6'(pend_idx_q);
      out_last_d   = pend_last_q;
      out_status_d = ST_GOOD;
    end else if (fail_load) begin
      out_valid_d  = 1'b1;
      out_byte_d   = '0;
      out_idx_d    = '0;
      out_last_d   = 1'b1;
      out_status_d = chk_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_HUNT1;
      fill_q      <= '0;
      gather_q    <= '0;
      cnt_q       <= '0;
      rp_q        <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      gather_q    <= gather_d;
      cnt_q       <= cnt_d;
      rp_q        <= rp_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    len_q        <= len_d;
    chk_q        <= chk_d;
    pend_idx_q   <= pend_idx_d;
    pend_last_q  <= pend_last_d;
    out_byte_q   <= out_byte_d;
    out_idx_q    <= out_idx_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  // Packet store.
  sfpc_ram #(
    .WIDTH (8),
    .DEPTH (PACKET_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (take_v),
    .waddr_i (fill_q[ADDR_W-1:0]),
    .wdata_i (take_b),
    .re_i    (issue),
    .raddr_i (rp_q),
    .rdata_o (rdata)
  );

  // Running CRC.
  sfpc_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (crc_cmd),
    .crc_o  (crc_val)
  );

  assign res_o.valid      = out_valid_q;
  assign res_o.out_byte   = out_byte_q;
  assign res_o.byte_index = out_idx_q;
  assign res_o.last       = out_last_q;
  assign res_o.status     = out_status_q;

  // A new result word never overwrites one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q || fail_load) |-> !out_valid_q || res_o.ready)
    else $error("result register overwritten");

  // Reads and writes of the packet store never share a cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(take_v && issue))
    else $error("packet store read and write collide");

  // The fill count never passes the packet size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(PACKET_BYTES))
    else $error("fill count out of range");

  // A CRC fold starts right after the fourth byte of a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CRC) |-> (fill_q[1:0] == 2'd0))
    else $error("CRC fold out of word alignment");

  // The check is reached only with the packet fully stored.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (fill_q == CNT_W'(PACKET_BYTES)))
    else $error("check before packet complete");

endmodule
